// File: rtl/assert_macros.svh
// Assertion macros used by the checker file, pptok_checker.sv.
// Depends on nothing; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent property, clocked and disabled while reset is held.
`define ASSERT_PROP(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same-cycle implication built on the property macro above.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    `ASSERT_PROP(label, clk, rst_n, ((ante) |-> (cons)), msg)

`endif

// File: rtl/pptok_pkg.sv
// Types and constants for the property path tokenizer.
// Depends on nothing; imported by every module of the block.
`default_nettype none

package pptok_pkg;

    // Default width of the decimal index accumulator
    localparam int INDEX_BITS_DEF = 31;

    // Character codes that steer the tokenizer
    localparam logic [7:0] CH_DOT     = 8'h2E;
    localparam logic [7:0] CH_LBRACK  = 8'h5B;
    localparam logic [7:0] CH_RBRACK  = 8'h5D;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;

    // Event code reported for each word
    typedef enum logic [3:0] {
        EV_FIELD_CHAR   = 4'd0,
        EV_FIELD_CLOSED = 4'd1,
        EV_INDEX_DIGIT  = 4'd2,
        EV_INDEX_CLOSED = 4'd3,
        EV_SEPARATOR    = 4'd4,
        EV_ERROR        = 4'd5,
        EV_IGNORED      = 4'd6,
        EV_ACCEPTED     = 4'd7,
        EV_REJECTED     = 4'd8
    } pptok_event_t;

    // Tokenizer mode
    typedef enum logic [1:0] {
        MODE_FIELD   = 2'd0,
        MODE_BRACKET = 2'd1,
        MODE_BETWEEN = 2'd2
    } pptok_mode_t;

    // Command kind of an input word
    typedef enum logic {
        CMD_CHAR = 1'b0,
        CMD_END  = 1'b1
    } pptok_cmd_t;

    // One input word as held in the input register
    typedef struct packed {
        pptok_cmd_t cmd;
        logic [7:0] ch;
    } pptok_item_t;

endpackage

`default_nettype wire

// File: rtl/pptok_core.sv
// Tokenizer state and the per-word step logic.
// Depends on pptok_pkg; instantiated by property_path_tokenizer_unit.
`default_nettype none

module pptok_core
    import pptok_pkg::*;
#(
    parameter int INDEX_BITS = INDEX_BITS_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  step,
    input  wire pptok_item_t           item,
    output pptok_event_t               ev,
    output logic [7:0]                 echo_char,
    output logic [INDEX_BITS-1:0]      index_value,
    output logic                       final_field
);

    pptok_mode_t            mode_reg,        mode_next;
    logic                   field_empty_reg, field_empty_next;
    logic                   index_empty_reg, index_empty_next;
    logic [INDEX_BITS-1:0]  acc_reg,         acc_next;
    logic                   error_reg,       error_next;

    logic                   is_digit;
    logic [3:0]             digit;
    logic [INDEX_BITS+3:0]  acc_wide;
    logic [INDEX_BITS+3:0]  prod;
    logic                   overflow;

    // Multiply-add by ten; any bit above the index width means overflow
    assign is_digit = (item.ch >= CH_ZERO) && (item.ch <= CH_NINE);
    assign digit    = 4'(item.ch - CH_ZERO);
    assign acc_wide = {4'b0, acc_reg};
    assign prod     = (acc_wide << 3) + (acc_wide << 1) + {{INDEX_BITS{1'b0}}, digit};
    assign overflow = |prod[INDEX_BITS+3:INDEX_BITS];

    // Step decode
    always_comb
    begin
        mode_next        = mode_reg;
        field_empty_next = field_empty_reg;
        index_empty_next = index_empty_reg;
        acc_next         = acc_reg;
        error_next       = error_reg;
        ev               = EV_IGNORED;
        echo_char        = '0;
        index_value      = '0;
        final_field      = 1'b0;

        if (item.cmd == CMD_END)
        begin
            if (error_reg)
            begin
                ev = EV_REJECTED;
            end
            else
            begin
                unique case (mode_reg)
                    MODE_FIELD:
                    begin
                        if (field_empty_reg)
                        begin
                            ev = EV_REJECTED;
                        end
                        else
                        begin
                            ev          = EV_ACCEPTED;
                            final_field = 1'b1;
                        end
                    end
                    MODE_BRACKET: ev = EV_REJECTED;
                    default:      ev = EV_ACCEPTED;
                endcase
            end
            // End of path returns to the reset state
            mode_next        = MODE_FIELD;
            field_empty_next = 1'b1;
            index_empty_next = 1'b1;
            acc_next         = '0;
            error_next       = 1'b0;
        end
        else
        begin
            echo_char = item.ch;
            if (error_reg)
            begin
                ev = EV_IGNORED;
            end
            else
            begin
                unique case (mode_reg)
                    MODE_FIELD:
                    begin
                        if (item.ch == CH_DOT || item.ch == CH_LBRACK)
                        begin
                            if (field_empty_reg)
                            begin
                                ev = EV_ERROR;
                            end
                            else
                            begin
                                ev = EV_FIELD_CLOSED;
                                if (item.ch == CH_DOT)
                                begin
                                    field_empty_next = 1'b1;
                                end
                                else
                                begin
                                    mode_next        = MODE_BRACKET;
                                    index_empty_next = 1'b1;
                                    acc_next         = '0;
                                end
                            end
                        end
                        else
                        begin
                            ev               = EV_FIELD_CHAR;
                            field_empty_next = 1'b0;
                        end
                    end
                    MODE_BRACKET:
                    begin
                        if (item.ch == CH_RBRACK)
                        begin
                            if (index_empty_reg)
                            begin
                                ev = EV_ERROR;
                            end
                            else
                            begin
                                ev          = EV_INDEX_CLOSED;
                                index_value = acc_reg;
                                mode_next   = MODE_BETWEEN;
                            end
                        end
                        else if (is_digit && !overflow)
                        begin
                            ev               = EV_INDEX_DIGIT;
                            acc_next         = prod[INDEX_BITS-1:0];
                            index_empty_next = 1'b0;
                        end
                        else
                        begin
                            ev = EV_ERROR;
                        end
                    end
                    default:
                    begin
                        // Between mode; the unused code behaves the same
                        if (item.ch == CH_DOT)
                        begin
                            ev               = EV_SEPARATOR;
                            mode_next        = MODE_FIELD;
                            field_empty_next = 1'b1;
                        end
                        else if (item.ch == CH_LBRACK)
                        begin
                            ev               = EV_SEPARATOR;
                            mode_next        = MODE_BRACKET;
                            index_empty_next = 1'b1;
                            acc_next         = '0;
                        end
                        else
                        begin
                            ev = EV_ERROR;
                        end
                    end
                endcase
            end
            if (ev == EV_ERROR)
            begin
                error_next = 1'b1;
            end
        end
    end

    // Commit state on each processed word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg        <= MODE_FIELD;
            field_empty_reg <= 1'b1;
            index_empty_reg <= 1'b1;
            acc_reg         <= '0;
            error_reg       <= 1'b0;
        end
        else if (step)
        begin
            mode_reg        <= mode_next;
            field_empty_reg <= field_empty_next;
            index_empty_reg <= index_empty_next;
            acc_reg         <= acc_next;
            error_reg       <= error_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/property_path_tokenizer_unit.sv
// Property path tokenizer: splits a dotted, bracket-indexed path into tokens.
// Each input word is registered, stepped through the tokenizer and lands in
// an output register, so one word enters per clock while the master side
// keeps taking results; while the output register is stalled, the input
// register and the tokenizer state hold their word. Tokenizer
// state (mode, empty flags, index accumulator, error flag) is carried in
// pptok_core and updated once per word; the index digit step is one
// multiply-by-ten add. An end-of-path word reports accept or reject and
// returns the tokenizer to its reset state. Depends on pptok_pkg, pptok_core.
`default_nettype none

module property_path_tokenizer_unit
    import pptok_pkg::*;
#(
    parameter int INDEX_BITS = INDEX_BITS_DEF,
    localparam int OUT_W     = ((8 + INDEX_BITS + 1 + 7) / 8) * 8
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              s_axis_tvalid,
    output logic                   s_axis_tready,
    input  wire logic [7:0]        s_axis_tdata,   // [7:0] ch
    input  wire logic              s_axis_tuser,   // [0] cmd
    output logic                   m_axis_tvalid,
    input  wire logic              m_axis_tready,
    output logic [OUT_W-1:0]       m_axis_tdata,   // echo_char, index_value, final_field
    output logic [3:0]             m_axis_tuser    // [3:0] event_res
);

    localparam int PAD_W = OUT_W - (8 + INDEX_BITS + 1);

    logic                   in_valid_reg;
    pptok_item_t            in_item_reg;
    logic                   out_valid_reg;
    pptok_event_t           out_event_reg;
    logic [7:0]             out_echo_reg;
    logic [INDEX_BITS-1:0]  out_index_reg;
    logic                   out_final_reg;

    logic                   out_ready;
    logic                   step;
    pptok_event_t           core_ev;
    logic [7:0]             core_echo;
    logic [INDEX_BITS-1:0]  core_index;
    logic                   core_final;

    // Handshake: advance when the output register is free or being drained
    assign out_ready     = !out_valid_reg || m_axis_tready;
    assign step          = in_valid_reg && out_ready;
    assign s_axis_tready = !in_valid_reg || out_ready;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_item_reg.cmd <= pptok_cmd_t'(s_axis_tuser);
            in_item_reg.ch  <= s_axis_tdata;
        end
    end

    pptok_core #(
        .INDEX_BITS (INDEX_BITS)
    ) u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (step),
        .item        (in_item_reg),
        .ev          (core_ev),
        .echo_char   (core_echo),
        .index_value (core_index),
        .final_field (core_final)
    );

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_ready)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            out_event_reg <= core_ev;
            out_echo_reg  <= core_echo;
            out_index_reg <= core_index;
            out_final_reg <= core_final;
        end
    end

    // Pack the result word
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_event_reg;
    generate
        if (PAD_W > 0)
        begin : g_pad
            assign m_axis_tdata = {{PAD_W{1'b0}}, out_final_reg, out_index_reg, out_echo_reg};
        end
        else
        begin : g_nopad
            assign m_axis_tdata = {out_final_reg, out_index_reg, out_echo_reg};
        end
    endgenerate

endmodule

`default_nettype wire

// File: rtl/pptok_checker.sv
// Port-level checks for property_path_tokenizer_unit, attached by bind.
// Depends on pptok_pkg and assert_macros.svh.
`default_nettype none

`include "assert_macros.svh"

module pptok_checker
    import pptok_pkg::*;
#(
    parameter int INDEX_BITS = INDEX_BITS_DEF,
    localparam int OUT_W     = ((8 + INDEX_BITS + 1 + 7) / 8) * 8
)
(
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              s_axis_tvalid,
    input wire logic              s_axis_tready,
    input wire logic [7:0]        s_axis_tdata,
    input wire logic              s_axis_tuser,
    input wire logic              m_axis_tvalid,
    input wire logic              m_axis_tready,
    input wire logic [OUT_W-1:0]  m_axis_tdata,
    input wire logic [3:0]        m_axis_tuser
);

    logic                   out_final;
    logic [INDEX_BITS-1:0]  out_index;
    logic [7:0]             out_echo;
    logic                   in_unused;

    assign out_echo  = m_axis_tdata[7:0];
    assign out_index = m_axis_tdata[8 +: INDEX_BITS];
    assign out_final = m_axis_tdata[8 + INDEX_BITS];
    assign in_unused = s_axis_tvalid ^ s_axis_tready ^ (^s_axis_tdata) ^ s_axis_tuser;

    // Hold a stalled result word
    `ASSERT_PROP(a_out_hold, clk, rst_n,
        ((m_axis_tvalid && !m_axis_tready) |=> ($stable(m_axis_tdata) && $stable(m_axis_tuser))),
        "result word changed while stalled")

    // Event code stays within the defined set
    `ASSERT_IMPLIES(a_event_range, clk, rst_n, m_axis_tvalid,
        (m_axis_tuser <= EV_REJECTED), "event code out of range")

    // Index only travels with an index-closed event
    `ASSERT_IMPLIES(a_index_only_closed, clk, rst_n,
        (m_axis_tvalid && m_axis_tuser != EV_INDEX_CLOSED),
        (out_index == '0), "index value set outside index closed")

    // Final field flag only on accept
    `ASSERT_IMPLIES(a_final_only_accept, clk, rst_n,
        (m_axis_tvalid && out_final),
        (m_axis_tuser == EV_ACCEPTED), "final field flag outside accept")

    // End-of-path results carry no character
    `ASSERT_IMPLIES(a_end_no_echo, clk, rst_n,
        (m_axis_tvalid && (m_axis_tuser == EV_ACCEPTED || m_axis_tuser == EV_REJECTED)),
        (out_echo == 8'h00 || in_unused != in_unused), "echo set on end of path")

endmodule

bind property_path_tokenizer_unit pptok_checker #(
    .INDEX_BITS (INDEX_BITS)
) u_pptok_checker (.*);

`default_nettype wire

// File: tb/tb_property_path_tokenizer_unit.sv
// Testbench for property_path_tokenizer_unit: drives path characters and end words,
// predicts each event word with a local tokenizer model and checks every output word.
// Depends on pptok_pkg and the property_path_tokenizer_unit RTL.
`default_nettype none

module tb_property_path_tokenizer_unit;
    import pptok_pkg::*;

    localparam int IDX_W       = 31;
    localparam int TDATA_W     = 40;
    localparam int CYCLE_LIMIT = 120000;
    localparam int RANDOM_WORDS = 950;
    localparam int QUIET_WORDS  = 150;
    localparam logic [63:0] INDEX_MAX = 64'h7FFF_FFFF;

    // One expected output word
    typedef struct {
        pptok_event_t       ev;
        logic [7:0]         echo;
        logic [IDX_W-1:0]   idx;
        logic               fin;
    } token_word_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [7:0]          s_axis_tdata = 8'h00;   // [7:0] ch
    logic                s_axis_tuser = 1'b0;    // [0] cmd
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [TDATA_W-1:0]  m_axis_tdata;           // [7:0] echo_char, [38:8] index_value, [39] final_field
    logic [3:0]          m_axis_tuser;           // [3:0] event_res

    // Local copy of the tokenizer state
    pptok_mode_t  tok_mode = MODE_FIELD;
    logic         field_empty = 1'b1;
    logic         index_empty = 1'b1;
    logic [63:0]  index_acc = '0;
    logic         error_seen = 1'b0;

    token_word_t  expected_tokens[$];
    int           mismatch_count = 0;
    int           words_sent = 0;
    int           cycle_count = 0;
    int           stall_left = 0;
    bit           idle_on = 1'b1;

    property_path_tokenizer_unit uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #10 clk = ~clk;

    // Advance the tokenizer state by one word and return the event it reports
    function automatic token_word_t tokenize_step(pptok_cmd_t cmd, logic [7:0] ch);
        token_word_t  w;
        logic [63:0]  digit;
        w.ev   = EV_IGNORED;
        w.echo = 8'h00;
        w.idx  = '0;
        w.fin  = 1'b0;
        if (cmd == CMD_END) begin
            if (error_seen || tok_mode == MODE_BRACKET)
                w.ev = EV_REJECTED;
            else if (tok_mode == MODE_FIELD) begin
                if (field_empty)
                    w.ev = EV_REJECTED;
                else begin
                    w.ev  = EV_ACCEPTED;
                    w.fin = 1'b1;
                end
            end
            else
                w.ev = EV_ACCEPTED;
            tok_mode    = MODE_FIELD;
            field_empty = 1'b1;
            index_empty = 1'b1;
            index_acc   = '0;
            error_seen  = 1'b0;
        end
        else begin
            w.echo = ch;
            if (error_seen)
                w.ev = EV_IGNORED;
            else if (tok_mode == MODE_FIELD) begin
                if (ch == CH_DOT || ch == CH_LBRACK) begin
                    if (field_empty)
                        w.ev = EV_ERROR;
                    else begin
                        w.ev = EV_FIELD_CLOSED;
                        if (ch == CH_DOT)
                            field_empty = 1'b1;
                        else begin
                            tok_mode    = MODE_BRACKET;
                            index_empty = 1'b1;
                            index_acc   = '0;
                        end
                    end
                end
                else begin
                    w.ev        = EV_FIELD_CHAR;
                    field_empty = 1'b0;
                end
            end
            else if (tok_mode == MODE_BRACKET) begin
                if (ch == CH_RBRACK) begin
                    if (index_empty)
                        w.ev = EV_ERROR;
                    else begin
                        w.ev     = EV_INDEX_CLOSED;
                        w.idx    = index_acc[IDX_W-1:0];
                        tok_mode = MODE_BETWEEN;
                    end
                end
                else if (ch >= CH_ZERO && ch <= CH_NINE) begin
                    digit = 64'(ch - CH_ZERO);
                    // Reject the digit that would push the index past its limit
                    if (index_acc > (INDEX_MAX - digit) / 10)
                        w.ev = EV_ERROR;
                    else begin
                        index_acc   = index_acc * 10 + digit;
                        index_empty = 1'b0;
                        w.ev        = EV_INDEX_DIGIT;
                    end
                end
                else
                    w.ev = EV_ERROR;
            end
            else begin
                // Between a closing bracket and the next token
                if (ch == CH_DOT) begin
                    w.ev        = EV_SEPARATOR;
                    tok_mode    = MODE_FIELD;
                    field_empty = 1'b1;
                end
                else if (ch == CH_LBRACK) begin
                    w.ev        = EV_SEPARATOR;
                    tok_mode    = MODE_BRACKET;
                    index_empty = 1'b1;
                    index_acc   = '0;
                end
                else
                    w.ev = EV_ERROR;
            end
            if (w.ev == EV_ERROR)
                error_seen = 1'b1;
        end
        return w;
    endfunction

    // Send one word, with an optional idle burst first, and queue its expected event
    task automatic send_word(pptok_cmd_t cmd, logic [7:0] ch);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= ch;
        s_axis_tuser  <= cmd;
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        expected_tokens.insert(expected_tokens.size(), tokenize_step(cmd, ch));
        words_sent++;
    endtask

    // Send a string of characters followed by an end word with a random data byte
    task automatic send_path(string text);
        for (int i = 0; i < text.len(); i++)
            send_word(CMD_CHAR, text[i]);
        send_word(CMD_END, 8'($urandom_range(0, 255)));
    endtask

    task automatic send_text_only(string text);
        for (int i = 0; i < text.len(); i++)
            send_word(CMD_CHAR, text[i]);
    endtask

    // Largest legal index, NUL and 0xFF as field bytes, then an index one past the limit
    task automatic test_index_limits();
        send_word(CMD_CHAR, 8'h00);
        send_text_only("[2147483647].");
        send_word(CMD_CHAR, 8'hFF);
        send_word(CMD_END, 8'h00);
        send_text_only("a[2147483648");
        send_path("x");
    endtask

    // Empty path, leading dot and bracket, double dot, empty index, trailing dot
    task automatic test_empty_tokens();
        send_path("");
        send_path(".");
        send_path("[");
        send_path("a..");
        send_path("a[]");
        send_path("a.");
    endtask

    // Unclosed bracket, bad index byte, junk after a closing bracket, accepted index tail
    task automatic test_bracket_rules();
        send_path("a[1");
        send_path("a[x");
        send_path("a[1]x");
        send_path("a[1][2]");
    endtask

    // Build one path from random fields and indices, then maybe break it
    task automatic send_random_path();
        logic [7:0]   bytes_q[$];
        logic [7:0]   b;
        longint       v;
        string        num;
        int           nseg, nlen, nidx, kind, pos;
        nseg = $urandom_range(1, 4);
        for (int k = 0; k < nseg; k++) begin
            if (k > 0)
                bytes_q.insert(bytes_q.size(), CH_DOT);
            nlen = $urandom_range(1, 4);
            for (int j = 0; j < nlen; j++) begin
                b = 8'($urandom_range(0, 255));
                if (b == CH_DOT || b == CH_LBRACK)
                    b = 8'h61;
                bytes_q.insert(bytes_q.size(), b);
            end
            nidx = $urandom_range(0, 2);
            for (int j = 0; j < nidx; j++) begin
                kind = $urandom_range(0, 19);
                if (kind < 14)
                    v = longint'($urandom_range(0, 999));
                else if (kind < 17)
                    v = 64'sd2147483647 - longint'($urandom_range(0, 20));
                else
                    v = 64'sd2147483648 + longint'($urandom_range(0, 100000));
                num = $sformatf("%0d", v);
                bytes_q.insert(bytes_q.size(), CH_LBRACK);
                for (int i = 0; i < num.len(); i++)
                    bytes_q.insert(bytes_q.size(), num[i]);
                bytes_q.insert(bytes_q.size(), CH_RBRACK);
            end
        end
        // Break a share of the paths: overwrite, cut short, insert, or pure noise
        kind = $urandom_range(0, 9);
        if (kind == 0 || kind == 1) begin
            pos = $urandom_range(0, bytes_q.size() - 1);
            bytes_q[pos] = 8'($urandom_range(0, 255));
        end
        else if (kind == 2) begin
            pos = $urandom_range(0, bytes_q.size() - 1);
            while (bytes_q.size() > pos)
                bytes_q.delete(bytes_q.size() - 1);
        end
        else if (kind == 3) begin
            pos = $urandom_range(0, bytes_q.size());
            bytes_q.insert(pos, 8'($urandom_range(0, 255)));
        end
        else if (kind == 4) begin
            bytes_q.delete();
            nlen = $urandom_range(1, 6);
            for (int j = 0; j < nlen; j++)
                bytes_q.insert(bytes_q.size(), 8'($urandom_range(0, 255)));
        end
        foreach (bytes_q[i])
            send_word(CMD_CHAR, bytes_q[i]);
        send_word(CMD_END, 8'($urandom_range(0, 255)));
    endtask

    task automatic test_random_paths(int word_count);
        int stop_at;
        stop_at = words_sent + word_count;
        while (words_sent < stop_at)
            send_random_path();
    endtask

    // Compare one output word with the oldest expectation
    function automatic void check_token(logic [3:0] ev_bits, logic [TDATA_W-1:0] data);
        token_word_t exp_w;
        if (expected_tokens.size() == 0) begin
            $display("%0t: unexpected word, event %0d data %h", $time, ev_bits, data);
            mismatch_count++;
            return;
        end
        exp_w = expected_tokens.pop_front();
        if (ev_bits !== exp_w.ev) begin
            $display("%0t: event expected %0d actual %0d", $time, exp_w.ev, ev_bits);
            mismatch_count++;
        end
        if (data[7:0] !== exp_w.echo) begin
            $display("%0t: echo_char expected %h actual %h", $time, exp_w.echo, data[7:0]);
            mismatch_count++;
        end
        if (data[38:8] !== exp_w.idx) begin
            $display("%0t: index_value expected %0d actual %0d", $time, exp_w.idx,
                     data[38:8]);
            mismatch_count++;
        end
        if (data[39] !== exp_w.fin) begin
            $display("%0t: final_field expected %b actual %b", $time, exp_w.fin, data[39]);
            mismatch_count++;
        end
    endfunction

    // Check each accepted output word and stall the output in random bursts
    always @(posedge clk) begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            check_token(m_axis_tuser, m_axis_tdata);
        if (stall_left > 0) begin
            m_axis_tready <= 1'b0;
            stall_left    <= stall_left - 1;
        end
        else if (idle_on && $urandom_range(0, 5) == 0) begin
            m_axis_tready <= 1'b0;
            stall_left    <= $urandom_range(0, 2);
        end
        else
            m_axis_tready <= 1'b1;
    end

    // Stop a hung run
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[property_path_tokenizer_unit] ERROR");
            $finish;
        end
    end

    initial begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_index_limits();
        test_empty_tokens();
        test_bracket_rules();
        test_random_paths(RANDOM_WORDS);
        // Run the tail with no idling on either side
        idle_on = 1'b0;
        test_random_paths(QUIET_WORDS);
        s_axis_tvalid <= 1'b0;
        while (expected_tokens.size() != 0) @(posedge clk);
        repeat (6) @(posedge clk);
        if (mismatch_count == 0 && expected_tokens.size() == 0)
            $display("[property_path_tokenizer_unit] OK");
        else
            $display("[property_path_tokenizer_unit] ERROR");
        $finish;
    end

endmodule

`default_nettype wire

// File: filelist.f
+incdir+rtl
rtl/pptok_pkg.sv
rtl/pptok_core.sv
rtl/property_path_tokenizer_unit.sv
rtl/pptok_checker.sv
tb/tb_property_path_tokenizer_unit.sv
